// ----- hw/rtl/wtbm_pkg.sv -----
`timescale 1ns / 1ps

package wtbm_pkg;

  localparam int IDX_W  = 16;
  localparam int VAL_W  = 48;
  localparam int SUM_W  = 64;
  localparam int DIST_W = 63;
  // |query - tag| with the shifted query folded in never exceeds 2^49 - 1
  localparam int DIFF_W = 49;
  // split points for the weight x distance partial products
  localparam int WLO_W  = 24;
  localparam int DLO_W  = 25;
  localparam int PROD_W = VAL_W + DIFF_W;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic [IDX_W-1:0]        candidate_index;
    logic                    has_tag;
    logic signed [VAL_W-1:0] tag_value;
    logic signed [VAL_W-1:0] query_value;
    logic signed [VAL_W-1:0] tag_weight;
    logic signed [VAL_W-1:0] wrap_range;
    logic                    last_tag_of_candidate;
    logic                    last_of_query;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  best_index;
    logic [DIST_W-1:0] best_distance;
  } out_item_t;

  // control that rides along the term pipeline
  typedef struct packed {
    logic [IDX_W-1:0] cand;
    logic             has_tag;
    logic             last_cand;
    logic             last_query;
  } item_ctl_t;

endpackage

// ----- hw/rtl/weighted_tag_best_match_core.sv -----
`timescale 1ns / 1ps

// Weighted best-match selector. Each input transaction carries one tag of
// one candidate; the block forms the wrapped distance to the query, scales
// it by the tag weight (fixed point, FRAC_BITS fraction bits, saturating)
// and accumulates it per candidate, keeping the candidate with the
// strictly smallest sum (first one wins ties). The transaction flagged
// last_of_query yields one result and clears the search state. One
// transaction is accepted every cycle while in_stall is low; a result
// passes the input register, the distance stage, the split 48x49-bit
// multiply (two stages) and the accumulate/compare logic into the output
// register. An output register plus one skid entry hold
// results; in_stall rises only while both are occupied.
module weighted_tag_best_match_core #(
  parameter int FRAC_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wtbm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wtbm_pkg::out_item_t  out_data
);

  import wtbm_pkg::*;

  logic                    adv;
  logic                    term_vld;
  item_ctl_t               term_ctl;
  logic signed [SUM_W-1:0] term;

  logic signed [SUM_W-1:0] run_sum_r;
  logic signed [SUM_W-1:0] best_sum_r;
  logic [IDX_W-1:0]        best_cand_r;

  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_add;
  logic signed [SUM_W-1:0] best_sum_upd;
  logic [IDX_W-1:0]        best_cand_upd;
  logic signed [SUM_W-1:0] run_sum_nxt;
  logic signed [SUM_W-1:0] best_sum_nxt;
  logic [IDX_W-1:0]        best_cand_nxt;
  out_item_t               res;
  logic                    res_vld;

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      skid_vld_r;
  out_item_t skid_r;
  logic      out_take;

  assign adv      = !skid_vld_r;
  assign in_stall = skid_vld_r;
  assign out_take = out_valid_r && !out_stall;

  wtbm_term #(
    .FRAC_BITS(FRAC_BITS)
  ) u_term (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_valid),
    .in_item  (in_data),
    .term_vld (term_vld),
    .term_ctl (term_ctl),
    .term     (term)
  );

  always_comb begin
    // saturating accumulate
    sum_wide = {run_sum_r[SUM_W-1], run_sum_r} + {term[SUM_W-1], term};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_add = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_add = sum_wide[SUM_W-1:0];
    end

    best_sum_upd  = best_sum_r;
    best_cand_upd = best_cand_r;
    run_sum_nxt   = sum_add;
    if (term_ctl.last_cand) begin
      if (best_sum_r > sum_add) begin
        best_sum_upd  = sum_add;
        best_cand_upd = term_ctl.cand;
      end
      run_sum_nxt = '0;
    end

    res.best_index    = best_cand_upd;
    res.best_distance = best_sum_upd[SUM_W-1] ? '0 : best_sum_upd[DIST_W-1:0];
    res_vld           = adv && term_vld && term_ctl.last_query;

    best_sum_nxt  = best_sum_upd;
    best_cand_nxt = best_cand_upd;
    if (term_ctl.last_query) begin
      run_sum_nxt   = '0;
      best_sum_nxt  = SUM_MAX;
      best_cand_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_sum_r   <= '0;
      best_sum_r  <= SUM_MAX;
      best_cand_r <= '0;
      out_valid_r <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else begin
      if (adv && term_vld) begin
        run_sum_r   <= run_sum_nxt;
        best_sum_r  <= best_sum_nxt;
        best_cand_r <= best_cand_nxt;
      end
      if (skid_vld_r) begin
        // drain skid into the output register
        if (out_take) begin
          skid_vld_r <= 1'b0;
        end
      end else if (res_vld) begin
        if (out_valid_r && !out_take) begin
          skid_vld_r <= 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) begin
        out_data_r <= skid_r;
      end
    end else if (res_vld) begin
      if (out_valid_r && !out_take) begin
        skid_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/wtbm_term.sv -----
`timescale 1ns / 1ps

module wtbm_term #(
  parameter int FRAC_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  in_vld,
  input  wtbm_pkg::in_item_t                    in_item,
  output logic                                  term_vld,
  output wtbm_pkg::item_ctl_t                   term_ctl,
  output logic signed [wtbm_pkg::SUM_W-1:0]     term
);

  import wtbm_pkg::*;

  localparam int DHI_W = DIFF_W - DLO_W;
  localparam int WHI_W = VAL_W - WLO_W;

  // stage 1: input register
  logic     s1_vld_r;
  in_item_t s1_item_r;

  // stage 2: distance and weight magnitude
  logic                    s2_vld_r;
  item_ctl_t               s2_ctl_r;
  logic                    s2_neg_r;
  logic [VAL_W-1:0]        s2_magw_r;
  logic [DIFF_W-1:0]       s2_diff_r;

  logic signed [VAL_W+1:0] shifted;
  logic signed [VAL_W:0]   d0s;
  logic signed [VAL_W+2:0] d1s;
  logic [DIFF_W-1:0]       d0;
  logic [DIFF_W:0]         d1;
  logic [DIFF_W-1:0]       diff_nxt;
  logic [VAL_W-1:0]        magw_nxt;
  item_ctl_t               ctl_nxt;

  // stage 3: partial products
  logic                          s3_vld_r;
  item_ctl_t                     s3_ctl_r;
  logic                          s3_neg_r;
  logic [WLO_W+DLO_W-1:0]        pp_ll_r;
  logic [WLO_W+DHI_W-1:0]        pp_lh_r;
  logic [WHI_W+DLO_W-1:0]        pp_hl_r;
  logic [WHI_W+DHI_W-1:0]        pp_hh_r;

  // stage 4: combine, scale, saturate
  logic                    s4_vld_r;
  item_ctl_t               s4_ctl_r;
  logic signed [SUM_W-1:0] s4_term_r;

  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       quot;
  logic [SUM_W-1:0]        mag;
  logic signed [SUM_W-1:0] term_nxt;

  always_comb begin
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic signed [VAL_W-1:0] r;
    logic signed [VAL_W-1:0] w;
    a = s1_item_r.query_value;
    b = s1_item_r.tag_value;
    r = s1_item_r.wrap_range;
    w = s1_item_r.tag_weight;
    // move the query one range toward zero
    if (!a[VAL_W-1]) begin
      shifted = {{2{a[VAL_W-1]}}, a} - {{2{r[VAL_W-1]}}, r};
    end else begin
      shifted = {{2{a[VAL_W-1]}}, a} + {{2{r[VAL_W-1]}}, r};
    end
    d0s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    d1s = {shifted[VAL_W+1], shifted} - {{3{b[VAL_W-1]}}, b};
    d0  = d0s[VAL_W] ? DIFF_W'(-d0s) : DIFF_W'(d0s);
    d1  = d1s[VAL_W+2] ? (DIFF_W+1)'(-d1s) : (DIFF_W+1)'(d1s);
    diff_nxt = ({1'b0, d0} < d1) ? d0 : d1[DIFF_W-1:0];
    magw_nxt = w[VAL_W-1] ? VAL_W'(-w) : VAL_W'(w);
    ctl_nxt.cand       = s1_item_r.candidate_index;
    ctl_nxt.has_tag    = s1_item_r.has_tag;
    ctl_nxt.last_cand  = s1_item_r.last_tag_of_candidate;
    ctl_nxt.last_query = s1_item_r.last_of_query;
  end

  always_comb begin
    prod = PROD_W'(pp_ll_r)
         + (PROD_W'(pp_lh_r) << DLO_W)
         + (PROD_W'(pp_hl_r) << WLO_W)
         + (PROD_W'(pp_hh_r) << (WLO_W + DLO_W));
    quot = prod >> FRAC_BITS;
    // saturate magnitude at the largest positive sum
    if (|quot[PROD_W-1:SUM_W-1]) begin
      mag = SUM_MAX;
    end else begin
      mag = {1'b0, quot[SUM_W-2:0]};
    end
    if (!s3_ctl_r.has_tag) begin
      term_nxt = '0;
    end else if (s3_neg_r) begin
      term_nxt = -$signed(mag);
    end else begin
      term_nxt = $signed(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= in_item;

      s2_ctl_r  <= ctl_nxt;
      s2_neg_r  <= s1_item_r.tag_weight[VAL_W-1];
      s2_magw_r <= magw_nxt;
      s2_diff_r <= diff_nxt;

      s3_ctl_r <= s2_ctl_r;
      s3_neg_r <= s2_neg_r;
      pp_ll_r  <= s2_magw_r[WLO_W-1:0] * s2_diff_r[DLO_W-1:0];
      pp_lh_r  <= s2_magw_r[WLO_W-1:0] * s2_diff_r[DIFF_W-1:DLO_W];
      pp_hl_r  <= s2_magw_r[VAL_W-1:WLO_W] * s2_diff_r[DLO_W-1:0];
      pp_hh_r  <= s2_magw_r[VAL_W-1:WLO_W] * s2_diff_r[DIFF_W-1:DLO_W];

      s4_ctl_r  <= s3_ctl_r;
      s4_term_r <= term_nxt;
    end
  end

  assign term_vld = s4_vld_r;
  assign term_ctl = s4_ctl_r;
  assign term     = s4_term_r;

endmodule
